FILE: hdl/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants and types of the census transform window block.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int PIX_W      = 8;
	localparam int CODE_W     = 25;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_RADIUS = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

FILE: hdl/cts_col_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_col_store
// Column history memory: one entry per image column holding the pixels of
// the previous rows, registered on read and written back, with forwarding
// when a write and a read hit the same column in the same cycle.
// ----------------------------------------------------------------------------
module cts_col_store #(
	parameter int DEPTH = 2048,
	parameter int ROWS  = 4
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               rd_en,
	input  wire  [$clog2(DEPTH)-1:0]          rd_addr,
	output logic [ROWS*cts_pkg::PIX_W-1:0]    rd_col,
	input  wire                               wr_en,
	input  wire  [$clog2(DEPTH)-1:0]          wr_addr,
	input  wire  [ROWS*cts_pkg::PIX_W-1:0]    wr_col
);

	localparam int DATA_W = ROWS * cts_pkg::PIX_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] fwd_data_q;
	logic              fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_col;
		end
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_col;
		end
	end

	// read during write returns old data, so take the written column instead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_col = fwd_q ? fwd_data_q : rdata_q;

	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (rd_addr == wr_addr) |=> rd_col === $past(wr_col))
		else $error("same-column write not forwarded");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_en |=> $stable(rd_col))
		else $error("column data changed without a read");

endmodule
`default_nettype wire

FILE: hdl/census_transform_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// census_transform_window
// Streaming 3x3 / 5x5 census transform over raster-order grayscale pixels.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock unless the output stalls: the column history
// memory is read when a word is accepted and written back as the word leaves
// stage 1, so each column costs one read and one write per word. A code is
// registered at the output after the word that completes its window, which
// is radius rows plus radius pixels after its own center pixel; after the
// frame the host sends that many padding words to drain it. Words that produce
// no code still travel the pipe. The memory needs no clearing pass after
// reset: rows and columns outside the image are masked off, so stale entries
// are never used. Writing width, height or radius restarts the frame.
// ----------------------------------------------------------------------------
module census_transform_window #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 2
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [cts_pkg::PIX_W-1:0]        pixel_value,
	input  wire                              is_padding,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [cts_pkg::CODE_W-1:0]       census_code,
	output logic                             last_of_frame,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [cts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [cts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PIX_W   = cts_pkg::PIX_W;
	localparam int ROW_W   = cts_pkg::ROW_W;
	localparam int DEPTH   = 2 * MAX_RADIUS + 1;
	localparam int STACK_N = 2 * MAX_RADIUS;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int WID_W   = $clog2(MAX_WIDTH + 1);
	localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
	localparam int LAG_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int IROW_W  = ROW_W + 1;
	localparam int RST_W   = (cts_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH :
		cts_pkg::RST_WIDTH;
	localparam int RST_R   = (cts_pkg::RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS :
		cts_pkg::RST_RADIUS;

	// configuration, held already clamped
	logic [WID_W-1:0]  w_q;
	logic [ROW_W-1:0]  h_q;
	logic [RAD_W-1:0]  r_q;
	logic              cfg_hit;

	// frame positions
	logic [COL_W-1:0]  in_col_q;
	logic [IROW_W-1:0] in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [LAG_W-1:0]  cnt_q;
	logic [LAG_W-1:0]  lag;

	logic              in_fire;
	logic              emit_now;
	logic              last_now;
	logic [PIX_W-1:0]  pix_now;
	logic [DEPTH-1:0]  row_ok_now;
	logic [DEPTH-1:0]  col_ok_now;

	// stage 1: column memory read returns
	logic              s1_valid_q;
	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              emit_s1;
	logic              last_s1;
	logic [DEPTH-1:0]  row_ok_s1;
	logic [DEPTH-1:0]  col_ok_s1;
	logic              s1_adv;
	logic              s1_free;

	logic [STACK_N*PIX_W-1:0] stack_rd;
	logic [STACK_N*PIX_W-1:0] stack_wr;
	logic [PIX_W-1:0]         col_px [DEPTH];

	// stage 2: window and compare
	logic              s2_valid_q;
	logic              emit_s2;
	logic              last_s2;
	logic [DEPTH-1:0]  row_ok_s2;
	logic [DEPTH-1:0]  col_ok_s2;
	logic              s2_adv;
	logic              s2_free;
	logic [PIX_W-1:0]  win_q [DEPTH][DEPTH];
	logic [PIX_W-1:0]  center;
	logic [cts_pkg::CODE_W-1:0] code;

	// output register
	logic              out_valid_q;
	logic [cts_pkg::CODE_W-1:0] code_q;
	logic              last_q;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (
		(cfg_index == cts_pkg::REG_WIDTH) ||
		(cfg_index == cts_pkg::REG_HEIGHT) ||
		(cfg_index == cts_pkg::REG_RADIUS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WID_W'(RST_W);
			h_q <= ROW_W'(cts_pkg::RST_HEIGHT);
			r_q <= RAD_W'(RST_R);
		end else if (cfg_valid) begin
			case (cts_pkg::cfg_reg_t'(cfg_index))
				cts_pkg::REG_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WID_W'(1);
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						w_q <= WID_W'(MAX_WIDTH);
					end else begin
						w_q <= WID_W'(cfg_data);
					end
				end
				cts_pkg::REG_HEIGHT: begin
					h_q <= (cfg_data == '0) ? ROW_W'(1) : ROW_W'(cfg_data);
				end
				cts_pkg::REG_RADIUS: begin
					if (cfg_data[1:0] == 2'd0) begin
						r_q <= RAD_W'(1);
					end else if (32'(cfg_data[1:0]) > MAX_RADIUS) begin
						r_q <= RAD_W'(MAX_RADIUS);
					end else begin
						r_q <= RAD_W'(cfg_data[1:0]);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage 0: positions, masks, memory read
	// ------------------------------------------------------------------
	assign lag      = LAG_W'(r_q) * LAG_W'(w_q) + LAG_W'(r_q);
	assign in_fire  = in_valid && in_ready;
	assign emit_now = (cnt_q == lag);
	assign last_now = (out_row_q == h_q - 1'b1) &&
		(out_col_q == COL_W'(w_q - 1'b1));
	assign pix_now  = (is_padding || (in_row_q >= IROW_W'(h_q))) ? '0 : pixel_value;

	always_comb begin
		logic [ROW_W+1:0] yy;
		logic [COL_W+1:0] xx;
		for (int k = 0; k < DEPTH; k++) begin
			yy = (ROW_W+2)'(out_row_q) + (ROW_W+2)'(r_q) - (ROW_W+2)'(k);
			xx = (COL_W+2)'(out_col_q) + (COL_W+2)'(r_q) - (COL_W+2)'(k);
			row_ok_now[k] = !yy[ROW_W+1] && (yy < (ROW_W+2)'(h_q));
			col_ok_now[k] = !xx[COL_W+1] && (xx < (COL_W+2)'(w_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnt_q     <= '0;
		end else if (cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnt_q     <= '0;
		end else if (in_fire) begin
			if (emit_now && last_now) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				cnt_q     <= '0;
			end else begin
				if (!emit_now) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (out_col_q == COL_W'(w_q - 1'b1)) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
				if (in_col_q == COL_W'(w_q - 1'b1)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// flow control
	// ------------------------------------------------------------------
	assign s2_adv   = s2_valid_q && (!emit_s2 || !out_valid_q || out_ready);
	assign s2_free  = !s2_valid_q || s2_adv;
	assign s1_adv   = s1_valid_q && s2_free;
	assign s1_free  = !s1_valid_q || s1_adv;
	assign in_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv && emit_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1    <= pix_now;
			col_s1    <= in_col_q;
			emit_s1   <= emit_now;
			last_s1   <= last_now;
			row_ok_s1 <= row_ok_now;
			col_ok_s1 <= col_ok_now;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: column history read-modify-write
	// ------------------------------------------------------------------
	cts_col_store #(
		.DEPTH (MAX_WIDTH),
		.ROWS  (STACK_N)
	) u_col_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (in_col_q),
		.rd_col  (stack_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_col  (stack_wr)
	);

	// column pixels, newest row first
	always_comb begin
		col_px[0] = pix_s1;
		for (int k = 1; k < DEPTH; k++) begin
			col_px[k] = stack_rd[(k-1)*PIX_W +: PIX_W];
		end
		for (int k = 0; k < STACK_N; k++) begin
			stack_wr[k*PIX_W +: PIX_W] = col_px[k];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int k = 0; k < DEPTH; k++) begin
				win_q[k][0] <= col_px[k];
				for (int j = 1; j < DEPTH; j++) begin
					win_q[k][j] <= win_q[k][j-1];
				end
			end
			emit_s2   <= emit_s1;
			last_s2   <= last_s1;
			row_ok_s2 <= row_ok_s1;
			col_ok_s2 <= col_ok_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: census compare
	// ------------------------------------------------------------------
	// row k counts up from the newest row, column j from the newest column
	always_comb begin
		center = win_q[1][1];
		code   = '0;
		for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
			if (r_q == RAD_W'(rr)) begin
				center = win_q[rr][rr];
			end
		end
		for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
			if (r_q == RAD_W'(rr)) begin
				for (int k = 0; k < 2 * rr + 1; k++) begin
					for (int j = 0; j < 2 * rr + 1; j++) begin
						code[k * (2 * rr + 1) + j] = (win_q[k][j] >= center) &&
							row_ok_s2[k] && col_ok_s2[j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && emit_s2) begin
			code_q <= code;
			last_q <= last_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign census_code   = code_q;
	assign last_of_frame = last_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WID_W'(in_col_q) < w_q) && (WID_W'(out_col_q) < w_q))
		else $error("column position beyond image width");

	a_lag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lag)
		else $error("startup count passed the window lag");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && emit_now && last_now && !cfg_hit |=>
			(in_col_q == '0) && (in_row_q == '0) && (out_row_q == '0) && (cnt_q == '0))
		else $error("positions not cleared after last word of frame");

endmodule
`default_nettype wire

FILE: dv/census_transform_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// census_transform_window_tb
// Streams raster frames of many sizes and both window radii into the census
// block. A behavioral window model predicts each code and end-of-frame flag,
// and every output word is checked in order under random source and sink
// pacing, register rewrites, cut frames and padding noise.
// ----------------------------------------------------------------------------
module census_transform_window_tb;

	localparam int PIX_W         = cts_pkg::PIX_W;
	localparam int CODE_W        = cts_pkg::CODE_W;
	localparam int CFG_IDX_W     = cts_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W    = cts_pkg::CFG_DATA_W;
	localparam int MAX_WIDTH     = 2048;
	localparam int MAX_RADIUS    = 2;
	localparam int HIST_DEPTH    = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_WORDS  = 280;
	localparam int TALL_WORDS    = 40;
	localparam int IDLE_PCT      = 75;
	localparam int BOTH_PCT      = 22;
	localparam int DIR_WORDS     = 17;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// 4x3 frame, radius 1: extremes, ties, padding inside the frame and a real
	// pixel inside the drain
	localparam logic [DIR_WORDS*PIX_W-1:0] DIR_PIX = {
		8'd0, 8'd255, 8'd128, 8'd128, 8'd1, 8'd254, 8'd255, 8'd127, 8'd64,
		8'd255, 8'd0, 8'd32, 8'd0, 8'd170, 8'd0, 8'd0, 8'd0};
	localparam logic [DIR_WORDS-1:0] DIR_PAD = 17'b000000_1_00000_1_0_111;

	typedef enum {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;
	typedef struct packed {logic [PIX_W-1:0] pix; logic pad;} pixel_word_t;
	typedef struct packed {logic [CODE_W-1:0] code; logic last;} code_word_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	wire                   in_ready;
	logic [PIX_W-1:0]      pixel_value = '0;
	logic                  is_padding  = 1'b0;
	wire                   out_valid;
	logic                  out_ready   = 1'b0;
	wire  [CODE_W-1:0]     census_code;
	wire                   last_of_frame;
	logic                  cfg_valid   = 1'b0;
	wire                   cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// window model state
	logic [PIX_W-1:0]      pix_hist [HIST_DEPTH];
	logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(cts_pkg::RST_WIDTH);
	logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(cts_pkg::RST_HEIGHT);
	logic [1:0]            radius_reg = 2'(cts_pkg::RST_RADIUS);
	int in_col = 0, in_row = 0, out_col = 0, out_row = 0;

	pixel_word_t pixel_words[$];
	code_word_t  expected_codes[$];

	int words_queued = 0, words_taken = 0, codes_checked = 0, errors = 0;
	int frames_sent = 0, reg_writes = 0, cycles = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;

	census_transform_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_value  (pixel_value),
		.is_padding   (is_padding),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.census_code  (census_code),
		.last_of_frame(last_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		return (height_reg == 0) ? 1 : int'(height_reg);
	endfunction

	function automatic int eff_radius();
		if (radius_reg == 0) return 1;
		if (radius_reg > MAX_RADIUS) return MAX_RADIUS;
		return int'(radius_reg);
	endfunction

	function automatic int frame_words();
		return eff_width() * eff_height() + eff_radius() * eff_width() + eff_radius();
	endfunction

	function automatic void restart_frame();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			cts_pkg::REG_WIDTH:  width_reg  = data;
			cts_pkg::REG_HEIGHT: height_reg = data;
			cts_pkg::REG_RADIUS: radius_reg = data[1:0];
			default: return;
		endcase
		restart_frame();
	endfunction

	function automatic logic [CODE_W-1:0] census_of(int w, int h, int r);
		int dy, dx, yy, xx;
		logic [PIX_W-1:0] ctr;
		logic [CODE_W-1:0] code;
		ctr  = pix_hist[(out_row * w + out_col) % HIST_DEPTH];
		code = '0;
		for (dy = -r; dy <= r; dy++) begin
			for (dx = -r; dx <= r; dx++) begin
				yy   = out_row + dy;
				xx   = out_col + dx;
				code = code << 1;
				if (yy >= 0 && yy < h && xx >= 0 && xx < w &&
						pix_hist[(yy * w + xx) % HIST_DEPTH] >= ctr)
					code[0] = 1'b1;
			end
		end
		return code;
	endfunction

	// one accepted pixel word: store it and emit the code it completes
	function automatic void absorb_word(logic [PIX_W-1:0] pix, logic pad);
		int w, h, r, n;
		code_word_t res;
		w = eff_width();
		h = eff_height();
		r = eff_radius();
		n = in_row * w + in_col;
		if (n < w * h)
			pix_hist[n % HIST_DEPTH] = pad ? '0 : pix;
		if (n >= r * w + r) begin
			res.code = census_of(w, h, r);
			res.last = (out_row == h - 1) && (out_col == w - 1);
			expected_codes.push_back(res);
			if (res.last) begin
				restart_frame();
				return;
			end
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
	endfunction

	function automatic void queue_word(pixel_word_t pw);
		pixel_words.push_back(pw);
		words_queued++;
	endfunction

	task automatic settle();
		@(posedge clk);
		while (words_taken != words_queued || expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		reg_writes++;
	endtask

	task automatic configure(int w, int h, int r);
		write_reg(cts_pkg::REG_WIDTH, CFG_DATA_W'(w));
		write_reg(cts_pkg::REG_HEIGHT, CFG_DATA_W'(h));
		write_reg(cts_pkg::REG_RADIUS, CFG_DATA_W'(r));
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pace(pace_t p);
		case (p)
			PACE_FULL: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND_IDLE: begin
				send_idle_pct  = IDLE_PCT;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALL: begin
				send_idle_pct  = 0;
				recv_stall_pct = IDLE_PCT;
			end
			default: begin
				send_idle_pct  = BOTH_PCT;
				recv_stall_pct = BOTH_PCT;
			end
		endcase
	endtask

	// random frame content, optionally cut short or paused for a spare write
	task automatic queue_frame(int stop_at, int pause_at);
		int k, total;
		pixel_word_t pw;
		total = eff_width() * eff_height();
		for (k = 0; k < stop_at; k++) begin
			if (k == pause_at) begin
				settle();
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
				cfg_valid <= 1'b0;
			end
			pw.pix = PIX_W'($urandom);
			if (k < total)
				pw.pad = ($urandom_range(99) < 8);
			else
				pw.pad = ($urandom_range(99) >= 15);
			queue_word(pw);
		end
		if (stop_at == frame_words())
			frames_sent++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			pixel_value <= '0;
			is_padding  <= 1'b0;
		end else begin : drive
			pixel_word_t nxt;
			if (in_valid && in_ready) begin
				absorb_word(pixel_value, is_padding);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pixel_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixel_words.pop_front();
					in_valid    <= 1'b1;
					pixel_value <= nxt.pix;
					is_padding  <= nxt.pad;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin : watch
			code_word_t want;
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					$display("%0t: unexpected word, code %h last %b", $time,
						census_code, last_of_frame);
					errors++;
				end else begin
					want = expected_codes.pop_front();
					codes_checked++;
					if (census_code !== want.code) begin
						$display("%0t: census_code expected %h got %h", $time,
							want.code, census_code);
						errors++;
					end
					if (last_of_frame !== want.last) begin
						$display("%0t: last_of_frame expected %b got %b", $time,
							want.last, last_of_frame);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d codes still pending", $time, expected_codes.size());
			$display("census_transform_window_tb failed");
			$finish;
		end
	end

	initial begin : stimulus
		int k, w, h, r, stop_at, rand_words, phase;
		pixel_word_t pw;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_pace(PACE_FULL);
		@(posedge clk);
		configure(4, 3, 1);
		for (k = 0; k < DIR_WORDS; k++) begin
			pw.pix = DIR_PIX[(DIR_WORDS - 1 - k) * PIX_W +: PIX_W];
			pw.pad = DIR_PAD[DIR_WORDS - 1 - k];
			queue_word(pw);
		end
		frames_sent++;
		settle();

		// out of range registers and extreme geometries
		set_pace(PACE_SEND_IDLE);
		configure(0, 0, 0);
		repeat (3) queue_frame(frame_words(), -1);
		settle();
		// tall single-column frame, dropped after its first codes
		set_pace(PACE_RECV_STALL);
		configure(1, 4095, 3);
		queue_frame(TALL_WORDS, -1);
		settle();
		set_pace(PACE_BOTH);
		configure(1, 1, 2);
		repeat (2) queue_frame(frame_words(), -1);
		settle();

		rand_words = 0;
		phase      = 0;
		while (rand_words < RANDOM_WORDS) begin
			set_pace(pace_t'(phase % 4));
			w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
			h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
			r = ($urandom_range(4) == 0) ? 3 * $urandom_range(1) : $urandom_range(1, 2);
			configure(w, h, r);
			repeat ($urandom_range(1, 3)) begin
				stop_at = frame_words();
				if ($urandom_range(99) < 15)
					stop_at = $urandom_range(1, stop_at - 1);
				queue_frame(stop_at,
					($urandom_range(9) == 0) ? $urandom_range(stop_at - 1) : -1);
				rand_words += stop_at;
			end
			settle();
			phase++;
		end

		settle();
		$display("checked %0d census codes from %0d pixel words", codes_checked, words_taken);
		$display("%0d whole frames, %0d register writes, %0d mismatches",
			frames_sent, reg_writes, errors);
		if (errors == 0)
			$display("census_transform_window_tb passed");
		else
			$display("census_transform_window_tb failed");
		$finish;
	end

endmodule

FILE: files.f
hdl/cts_pkg.sv
hdl/cts_col_store.sv
hdl/census_transform_window.sv
dv/census_transform_window_tb.sv
